// ===== src/ptrs_pkg.sv =====
// Package for the periodic tile rectangle sum block.
// Holds the widths, the queue item type, the control states and small helpers.
// No dependencies.
`default_nettype none
package ptrs_pkg;

  localparam int MAX_SEEDS     = 16;
  localparam int SEED_IDX_BITS = 4;
  localparam int VALUE_BITS    = 32;
  localparam int COORD_BITS    = 27;
  localparam int SUM_BITS      = 64;
  localparam int HP_BITS       = 5;
  localparam int SIDE_BITS     = 5;
  localparam int TBL_ADDR_BITS = 2 * SIDE_BITS;
  localparam int TBL_DEPTH     = 1 << TBL_ADDR_BITS;
  localparam int QW            = COORD_BITS + 1;
  localparam int QW_CNT_BITS   = $clog2(QW);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [SEED_IDX_BITS-1:0] seed_index;
    logic [VALUE_BITS-1:0]   seed_value;
    logic                    seed_last;
    logic [COORD_BITS-1:0]   row_low;
    logic [COORD_BITS-1:0]   col_low;
    logic [COORD_BITS-1:0]   row_high;
    logic [COORD_BITS-1:0]   col_high;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BREAD,
    S_BWRITE,
    S_QDIV,
    S_QREAD,
    S_QMUL,
    S_OUT
  } state_t;

  // Sum of two residues below n, reduced once more modulo n.
  function automatic logic [SEED_IDX_BITS-1:0] add_mod(
    input logic [SEED_IDX_BITS-1:0] a,
    input logic [SEED_IDX_BITS-1:0] b,
    input logic [HP_BITS-1:0]       n
  );
    logic [HP_BITS-1:0] s;
    s = HP_BITS'(a) + HP_BITS'(b);
    if (s >= n) begin
      s = s - n;
    end
    return s[SEED_IDX_BITS-1:0];
  endfunction

  // Seed count in use: zero acts as one, large values saturate.
  function automatic logic [HP_BITS-1:0] clamp_n(input logic [HP_BITS-1:0] hp);
    logic [HP_BITS-1:0] r;
    r = hp;
    if (hp == '0) begin
      r = HP_BITS'(1);
    end else if (hp > HP_BITS'(MAX_SEEDS)) begin
      r = HP_BITS'(MAX_SEEDS);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/ptrs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module ptrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/ptrs_front.sv =====
// Front end: accepts input items, tags each as a load or a query and holds
// them in a two-entry queue for the back end. Depends on ptrs_pkg.
`default_nettype none
module ptrs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [ptrs_pkg::SEED_IDX_BITS-1:0] seed_index,
  input  logic [ptrs_pkg::VALUE_BITS-1:0]    seed_value,
  input  logic                               seed_last,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_high,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_high,
  output logic                               q_valid,
  output ptrs_pkg::item_t                    q_item,
  input  logic                               q_pop
);

  ptrs_pkg::item_t entry [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;
  ptrs_pkg::item_t in_item;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rptr];

  always_comb begin
    in_item.op         = cmd ? ptrs_pkg::OP_QUERY : ptrs_pkg::OP_LOAD;
    in_item.seed_index = seed_index;
    in_item.seed_value = seed_value;
    in_item.seed_last  = seed_last;
    in_item.row_low    = row_low;
    in_item.col_low    = col_low;
    in_item.row_high   = row_high;
    in_item.col_high   = col_high;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= in_item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/ptrs_back.sv =====
// Back end: seed store, table build sequencer, query divider, serial
// multiplier and output register. Depends on ptrs_pkg and ptrs_ram.
`default_nettype none
module ptrs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ptrs_pkg::HP_BITS-1:0]  half_period,
  input  logic                          q_valid,
  input  ptrs_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptrs_pkg::SUM_BITS-1:0] rect_sum
);

  localparam int SB = ptrs_pkg::SIDE_BITS;
  localparam int MB = ptrs_pkg::SEED_IDX_BITS;
  localparam int NB = ptrs_pkg::HP_BITS;
  localparam int W  = ptrs_pkg::SUM_BITS;
  localparam int QW = ptrs_pkg::QW;
  localparam int CB = ptrs_pkg::QW_CNT_BITS;

  // Divider lanes.
  localparam int LN_RH = 0;
  localparam int LN_RL = 1;
  localparam int LN_CH = 2;
  localparam int LN_CL = 3;

  // Table reads of one query, in issue order.
  localparam logic [3:0] RD_TILE  = 4'd0;
  localparam logic [3:0] RD_ROWH  = 4'd1;
  localparam logic [3:0] RD_ROWL  = 4'd2;
  localparam logic [3:0] RD_COLH  = 4'd3;
  localparam logic [3:0] RD_COLL  = 4'd4;
  localparam logic [3:0] RD_HH    = 4'd5;
  localparam logic [3:0] RD_LH    = 4'd6;
  localparam logic [3:0] RD_HL    = 4'd7;
  localparam logic [3:0] RD_LL    = 4'd8;
  localparam logic [3:0] RD_COUNT = 4'd9;

  ptrs_pkg::state_t state, state_next;

  logic [ptrs_pkg::VALUE_BITS-1:0] seed [ptrs_pkg::MAX_SEEDS];
  logic                  ready;
  logic [NB-1:0]         nb;
  logic [SB-1:0]         lm1;
  logic [SB-1:0]         blt_lm1;
  logic [SB-1:0]         br, bc;
  logic [MB-1:0]         km, dp, km0, rp;
  logic [W-1:0]          rowacc;
  logic                  bwrite_last;
  logic [NB-1:0]         n_new;
  logic [SB:0]           side_new;
  logic [W-1:0]          row_next;

  logic                            wr_en;
  logic [ptrs_pkg::TBL_ADDR_BITS-1:0] wr_addr, rd_addr, q_addr;
  logic [W-1:0]                    wr_data, rd_data;

  logic [QW-1:0]   dv   [4];
  logic [SB-1:0]   rem  [4];
  logic [QW-1:0]   dv_next  [4];
  logic [SB-1:0]   rem_next [4];
  logic [CB-1:0]   dcnt;
  logic [SB:0]     side;

  logic [3:0]      ridx;
  logic            q_zero, zero_d;
  logic [W-1:0]    cap_val;
  logic [W-1:0]    tval, rowd, cold, acc;
  logic [QW-1:0]   dr, dc;

  logic [W-1:0]    mx, prod, step_add;
  logic [QW-1:0]   my;
  logic [CB-1:0]   mcnt;
  logic [1:0]      mph;
  logic            mul_end;

  assign bwrite_last = (bc == lm1) && (br == lm1);
  assign n_new       = ptrs_pkg::clamp_n(half_period);
  assign side_new    = {n_new, 1'b0};
  assign side        = {1'b0, blt_lm1} + (SB+1)'(1);
  assign dr          = dv[LN_RH] - dv[LN_RL];
  assign dc          = dv[LN_CH] - dv[LN_CL];
  assign mul_end     = (mcnt == CB'(QW - 1));
  assign row_next    = rowacc + W'(seed[km]);

  // Control sequencer.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ptrs_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == ptrs_pkg::OP_LOAD) begin
            state_next = q_item.seed_last ? ptrs_pkg::S_BREAD : ptrs_pkg::S_IDLE;
          end else begin
            state_next = ready ? ptrs_pkg::S_QDIV : ptrs_pkg::S_OUT;
          end
        end
      end
      ptrs_pkg::S_BREAD:  state_next = ptrs_pkg::S_BWRITE;
      ptrs_pkg::S_BWRITE: state_next = bwrite_last ? ptrs_pkg::S_IDLE : ptrs_pkg::S_BREAD;
      ptrs_pkg::S_QDIV: begin
        if (dcnt == CB'(QW - 1)) begin
          state_next = ptrs_pkg::S_QREAD;
        end
      end
      ptrs_pkg::S_QREAD: begin
        if (ridx == RD_COUNT) begin
          state_next = ptrs_pkg::S_QMUL;
        end
      end
      ptrs_pkg::S_QMUL: begin
        if (mul_end && mph == 2'd3) begin
          state_next = ptrs_pkg::S_OUT;
        end
      end
      ptrs_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = ptrs_pkg::S_IDLE;
        end
      end
      default: state_next = ptrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptrs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query table addresses; a prefix at coordinate minus one reads as zero.
  always_comb begin
    q_addr = '0;
    q_zero = 1'b1;
    case (ridx)
      RD_TILE: begin
        q_addr = {blt_lm1, blt_lm1};
        q_zero = 1'b0;
      end
      RD_ROWH: begin
        q_addr = {rem[LN_RH] - SB'(1), blt_lm1};
        q_zero = (rem[LN_RH] == '0);
      end
      RD_ROWL: begin
        q_addr = {rem[LN_RL] - SB'(1), blt_lm1};
        q_zero = (rem[LN_RL] == '0);
      end
      RD_COLH: begin
        q_addr = {blt_lm1, rem[LN_CH] - SB'(1)};
        q_zero = (rem[LN_CH] == '0);
      end
      RD_COLL: begin
        q_addr = {blt_lm1, rem[LN_CL] - SB'(1)};
        q_zero = (rem[LN_CL] == '0);
      end
      RD_HH: begin
        q_addr = {rem[LN_RH] - SB'(1), rem[LN_CH] - SB'(1)};
        q_zero = (rem[LN_RH] == '0) || (rem[LN_CH] == '0);
      end
      RD_LH: begin
        q_addr = {rem[LN_RL] - SB'(1), rem[LN_CH] - SB'(1)};
        q_zero = (rem[LN_RL] == '0) || (rem[LN_CH] == '0);
      end
      RD_HL: begin
        q_addr = {rem[LN_RH] - SB'(1), rem[LN_CL] - SB'(1)};
        q_zero = (rem[LN_RH] == '0) || (rem[LN_CL] == '0);
      end
      RD_LL: begin
        q_addr = {rem[LN_RL] - SB'(1), rem[LN_CL] - SB'(1)};
        q_zero = (rem[LN_RL] == '0) || (rem[LN_CL] == '0);
      end
      default: begin
        q_addr = '0;
        q_zero = 1'b1;
      end
    endcase
  end

  assign rd_addr = (state == ptrs_pkg::S_BREAD) ? {br - SB'(1), bc} : q_addr;
  assign wr_en   = (state == ptrs_pkg::S_BWRITE);
  assign wr_addr = {br, bc};
  assign wr_data = ((br == '0) ? W'(0) : rd_data) + row_next;
  assign cap_val = zero_d ? W'(0) : rd_data;

  // One restoring division step per lane and cycle.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [SB:0] t;
      t = {rem[i], dv[i][QW-1]};
      if (t >= side) begin
        t = t - side;
        dv_next[i] = {dv[i][QW-2:0], 1'b1};
      end else begin
        dv_next[i] = {dv[i][QW-2:0], 1'b0};
      end
      rem_next[i] = t[SB-1:0];
    end
  end

  // Serial signed multiply: the top bit of the multiplier weighs negative.
  always_comb begin
    step_add = prod;
    if (my[0]) begin
      step_add = mul_end ? (prod - mx) : (prod + mx);
    end
  end

  always_ff @(posedge clk) begin
    zero_d <= q_zero;
    case (state)
      ptrs_pkg::S_IDLE: begin
        if (q_valid && q_item.op == ptrs_pkg::OP_LOAD) begin
          seed[q_item.seed_index] <= q_item.seed_value;
          nb     <= n_new;
          lm1    <= SB'(side_new - (SB+1)'(1));
          br     <= '0;
          bc     <= '0;
          km     <= '0;
          km0    <= '0;
          dp     <= (n_new == NB'(1)) ? MB'(0) : MB'(1);
          rp     <= (n_new <= NB'(2)) ? MB'(0) : MB'(2);
          rowacc <= '0;
        end
        if (q_valid && q_item.op == ptrs_pkg::OP_QUERY) begin
          acc            <= '0;
          dcnt           <= '0;
          ridx           <= '0;
          dv[LN_RH]      <= {1'b0, q_item.row_high} + QW'(1);
          dv[LN_RL]      <= {1'b0, q_item.row_low};
          dv[LN_CH]      <= {1'b0, q_item.col_high} + QW'(1);
          dv[LN_CL]      <= {1'b0, q_item.col_low};
          for (int i = 0; i < 4; i++) begin
            rem[i] <= '0;
          end
        end
      end
      ptrs_pkg::S_BWRITE: begin
        rowacc <= row_next;
        if (bc == lm1) begin
          br     <= br + SB'(1);
          bc     <= '0;
          rowacc <= '0;
          km     <= ptrs_pkg::add_mod(km0, rp, nb);
          km0    <= ptrs_pkg::add_mod(km0, rp, nb);
          dp     <= rp;
          rp     <= ptrs_pkg::add_mod(rp, MB'(1), nb);
        end else begin
          bc <= bc + SB'(1);
          km <= ptrs_pkg::add_mod(km, dp, nb);
          dp <= ptrs_pkg::add_mod(dp, MB'(1), nb);
        end
      end
      ptrs_pkg::S_QDIV: begin
        dcnt <= dcnt + CB'(1);
        for (int i = 0; i < 4; i++) begin
          dv[i]  <= dv_next[i];
          rem[i] <= rem_next[i];
        end
      end
      ptrs_pkg::S_QREAD: begin
        ridx <= ridx + 4'd1;
        case (ridx - 4'd1)
          RD_TILE: tval <= cap_val;
          RD_ROWH: rowd <= cap_val;
          RD_ROWL: rowd <= rowd - cap_val;
          RD_COLH: cold <= cap_val;
          RD_COLL: cold <= cold - cap_val;
          RD_HH:   acc  <= acc + cap_val;
          RD_LH:   acc  <= acc - cap_val;
          RD_HL:   acc  <= acc - cap_val;
          RD_LL:   acc  <= acc + cap_val;
          default: acc  <= acc;
        endcase
        if (ridx == RD_COUNT) begin
          mx   <= tval;
          my   <= dc;
          prod <= '0;
          mcnt <= '0;
          mph  <= 2'd0;
        end
      end
      ptrs_pkg::S_QMUL: begin
        if (mul_end) begin
          prod <= '0;
          mcnt <= '0;
          mph  <= mph + 2'd1;
          case (mph)
            2'd0: begin
              mx <= step_add;
              my <= dr;
            end
            2'd1: begin
              acc <= acc + step_add;
              mx  <= rowd;
              my  <= dc;
            end
            2'd2: begin
              acc <= acc + step_add;
              mx  <= cold;
              my  <= dr;
            end
            default: acc <= acc + step_add;
          endcase
        end else begin
          prod <= step_add;
          mx   <= mx << 1;
          my   <= my >> 1;
          mcnt <= mcnt + CB'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ptrs_pkg::S_OUT && (!out_valid || !out_stall)) begin
      rect_sum <= acc;
    end
    if (rst) begin
      ready     <= 1'b0;
      blt_lm1   <= SB'(1);
      out_valid <= 1'b0;
    end else begin
      if (state == ptrs_pkg::S_BWRITE && bwrite_last) begin
        ready   <= 1'b1;
        blt_lm1 <= lm1;
      end
      if (state == ptrs_pkg::S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  ptrs_ram #(
    .WIDTH(W),
    .DEPTH(ptrs_pkg::TBL_DEPTH)
  ) u_prefix (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

`ifndef ASSERT_OFF
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ptrs_pkg::S_BWRITE |-> $past(state) == ptrs_pkg::S_BREAD)
    else $error("table write without a preceding read");
  a_ready_holds: assert property (@(posedge clk) disable iff (rst)
    ready |=> ready)
    else $error("table ready dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ptrs_pkg::S_IDLE && q_valid))
    else $error("queue popped outside idle");
  a_residue: assert property (@(posedge clk) disable iff (rst)
    state == ptrs_pkg::S_BWRITE |-> (NB'(km) < nb && NB'(dp) < nb))
    else $error("seed residue out of range");
`endif

endmodule
`default_nettype wire

// ===== src/periodic_tile_rectangle_sum.sv =====
// Top level of the periodic tile rectangle sum block.
// Holds the half period register and joins ptrs_front and ptrs_back.
// Depends on ptrs_pkg, ptrs_front, ptrs_back and ptrs_ram.
//
// Usage: load items (cmd 0) write seed values; the load with seed_last set
// starts a build of the 2n by 2n tile and its summed-area table, with one read
// and one write of the table memory per entry. Query items (cmd 1) return one
// rect_sum each; a load returns nothing. A query runs a one bit per cycle
// divider (four lanes in parallel), then table reads through the single read
// port, then four serial multiplications. Items enter a two-entry queue, so
// in_stall rises only when the queue is full while the back end is busy. The
// result sits in an output register until taken; while out_stall is high it
// holds and the back end waits there. Configuration is written on the cfg
// channel, always ready; the user must write it only while idle, and the
// block itself does not enforce this. Reset is synchronous: queue empty, no
// table built (queries return zero), half period 1. Memories are not cleared.
`default_nettype none
module periodic_tile_rectangle_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptrs_pkg::HP_BITS-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [ptrs_pkg::SEED_IDX_BITS-1:0] seed_index,
  input  logic [ptrs_pkg::VALUE_BITS-1:0]    seed_value,
  input  logic                               seed_last,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_high,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptrs_pkg::SUM_BITS-1:0]      rect_sum
);

  logic [ptrs_pkg::HP_BITS-1:0] half_period;
  logic                         q_valid;
  logic                         q_pop;
  ptrs_pkg::item_t              q_item;

  assign cfg_ready = 1'b1;

  // The half period register; it is sampled when a build starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= ptrs_pkg::HP_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  ptrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .seed_index(seed_index),
    .seed_value(seed_value),
    .seed_last (seed_last),
    .row_low   (row_low),
    .col_low   (col_low),
    .row_high  (row_high),
    .col_high  (col_high),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ptrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .half_period(half_period),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rect_sum   (rect_sum)
  );

endmodule
`default_nettype wire

// ===== bench/ptrs_checker.sv =====
// Checker for the periodic tile rectangle sum block: watches the configuration,
// input and output channels, predicts every rect_sum and compares it.
// Depends on ptrs_pkg for widths and the operation codes.
module ptrs_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ptrs_pkg::HP_BITS-1:0]       cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               cmd,
  input  logic [ptrs_pkg::SEED_IDX_BITS-1:0] seed_index,
  input  logic [ptrs_pkg::VALUE_BITS-1:0]    seed_value,
  input  logic                               seed_last,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_low,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    row_high,
  input  logic [ptrs_pkg::COORD_BITS-1:0]    col_high,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [ptrs_pkg::SUM_BITS-1:0]      rect_sum,
  output int                                 fail_count,
  output int                                 sums_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ptrs_pkg::VALUE_BITS-1:0] seeds [0:ptrs_pkg::MAX_SEEDS-1];
  logic [ptrs_pkg::SUM_BITS-1:0]   area  [0:2*ptrs_pkg::MAX_SEEDS-1][0:2*ptrs_pkg::MAX_SEEDS-1];
  logic [ptrs_pkg::HP_BITS-1:0]    half_reg;
  logic                            tile_built;
  int                              tile_side;
  logic [ptrs_pkg::SUM_BITS-1:0]   sum_queue [$];

  // Rebuild the summed-area table of the 2n by 2n tile.
  function automatic void build_area();
    int n, d, k;
    logic [ptrs_pkg::SUM_BITS-1:0] s;
    n = (half_reg == 0) ? 1 :
        ((half_reg > ptrs_pkg::MAX_SEEDS) ? ptrs_pkg::MAX_SEEDS : int'(half_reg));
    tile_side = 2 * n;
    for (int r = 0; r < tile_side; r++) begin
      for (int c = 0; c < tile_side; c++) begin
        d = r + c;
        k = d * (d + 1) / 2 + r;
        s = ptrs_pkg::SUM_BITS'(seeds[k % n]);
        if (r > 0) s += area[r-1][c];
        if (c > 0) s += area[r][c-1];
        if (r > 0 && c > 0) s -= area[r-1][c-1];
        area[r][c] = s;
      end
    end
    tile_built = 1'b1;
  endfunction

  function automatic logic [ptrs_pkg::SUM_BITS-1:0] corner_sum(int rr, int cc);
    if (rr == 0 || cc == 0) return '0;
    return area[rr-1][cc-1];
  endfunction

  // Sum over plane rows below a and columns below b.
  function automatic logic [ptrs_pkg::SUM_BITS-1:0] plane_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] qa, qb, res;
    int ra, rb;
    qa = a / tile_side;
    qb = b / tile_side;
    ra = int'(a % tile_side);
    rb = int'(b % tile_side);
    res = qa * qb * corner_sum(tile_side, tile_side);
    res += qb * corner_sum(ra, tile_side);
    res += qa * corner_sum(tile_side, rb);
    res += corner_sum(ra, rb);
    return res;
  endfunction

  function automatic logic [ptrs_pkg::SUM_BITS-1:0] rect_expect();
    logic [63:0] rl, cl, rh, ch;
    if (!tile_built) return '0;
    rl = 64'(row_low);
    cl = 64'(col_low);
    rh = 64'(row_high) + 1;
    ch = 64'(col_high) + 1;
    return plane_sum(rh, ch) - plane_sum(rl, ch) - plane_sum(rh, cl) + plane_sum(rl, cl);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      half_reg   <= ptrs_pkg::HP_BITS'(1);
      tile_built <= 1'b0;
      tile_side  <= 2;
      sum_queue.delete();
      fail_count   <= 0;
      sums_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sum_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected rect_sum %h", rect_sum);
        end else begin
          if (sum_queue[0] !== rect_sum) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("rect_sum mismatch: expected %h actual %h", sum_queue[0], rect_sum);
          end
          void'(sum_queue.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        if (ptrs_pkg::op_t'(cmd) == ptrs_pkg::OP_LOAD) begin
          seeds[seed_index] = seed_value;
          if (seed_last) build_area();
        end else begin
          sum_queue.push_back(rect_expect());
        end
      end
      if (cfg_valid && cfg_ready) half_reg <= cfg_data;
      sums_pending <= sum_queue.size();
    end
  end

endmodule

// ===== bench/tb_periodic_tile_rectangle_sum.sv =====
// Testbench top for the periodic tile rectangle sum block: drives directed and
// random load and query items under several idling phases and gives the verdict.
// Depends on ptrs_pkg, periodic_tile_rectangle_sum and ptrs_checker.
module tb_periodic_tile_rectangle_sum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX   = (1 << ptrs_pkg::COORD_BITS) - 1;
  // Longest quiet stretch: a full build plus the settle wait.
  localparam int SETTLE      = 2500;
  localparam int QUIET_LIMIT = 50000;

  logic                               clk, rst;
  logic                               cfg_valid, cfg_ready;
  logic [ptrs_pkg::HP_BITS-1:0]       cfg_data;
  logic                               in_valid, in_stall;
  logic                               cmd;
  logic [ptrs_pkg::SEED_IDX_BITS-1:0] seed_index;
  logic [ptrs_pkg::VALUE_BITS-1:0]    seed_value;
  logic                               seed_last;
  logic [ptrs_pkg::COORD_BITS-1:0]    row_low, col_low, row_high, col_high;
  logic                               out_valid, out_stall;
  logic [ptrs_pkg::SUM_BITS-1:0]      rect_sum;
  int                                 fail_count, sums_pending;
  int                                 send_idle_pct, recv_stall_pct;
  int                                 active_side;
  int                                 quiet_cycles;

  periodic_tile_rectangle_sum u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .seed_index(seed_index), .seed_value(seed_value), .seed_last(seed_last),
    .row_low(row_low), .col_low(col_low), .row_high(row_high), .col_high(col_high),
    .out_valid(out_valid), .out_stall(out_stall), .rect_sum(rect_sum)
  );

  ptrs_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .seed_index(seed_index), .seed_value(seed_value), .seed_last(seed_last),
    .row_low(row_low), .col_low(col_low), .row_high(row_high), .col_high(col_high),
    .out_valid(out_valid), .out_stall(out_stall), .rect_sum(rect_sum),
    .fail_count(fail_count), .sums_pending(sums_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase; at zero
  // percent the output is taken every cycle.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any accepted item on any channel resets the quiet counter.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one item and hold it steady until the block takes it. Idle gaps
  // come before the item so valid is never dropped and raised in one step.
  task automatic send_item(input ptrs_pkg::item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= it.op;
    seed_index <= it.seed_index;
    seed_value <= it.seed_value;
    seed_last  <= it.seed_last;
    row_low    <= it.row_low;
    col_low    <= it.col_low;
    row_high   <= it.row_high;
    col_high   <= it.col_high;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_load(input int idx, input logic [ptrs_pkg::VALUE_BITS-1:0] val,
                           input logic last);
    ptrs_pkg::item_t it;
    logic [159:0]    raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(ptrs_pkg::item_t)-1:0];
    it.op         = ptrs_pkg::OP_LOAD;
    it.seed_index = ptrs_pkg::SEED_IDX_BITS'(idx);
    it.seed_value = val;
    it.seed_last  = last;
    send_item(it);
  endtask

  task automatic send_query(input int rl, input int cl, input int rh, input int ch);
    ptrs_pkg::item_t it;
    logic [159:0]    raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(ptrs_pkg::item_t)-1:0];
    it.op       = ptrs_pkg::OP_QUERY;
    it.row_low  = ptrs_pkg::COORD_BITS'(rl);
    it.col_low  = ptrs_pkg::COORD_BITS'(cl);
    it.row_high = ptrs_pkg::COORD_BITS'(rh);
    it.col_high = ptrs_pkg::COORD_BITS'(ch);
    send_item(it);
  endtask

  // Pick one edge pair of a query: mostly a few tiles from the origin, some
  // spread over the full range, some near the top, and a few reversed.
  task automatic pick_span(output int lo, output int hi);
    int mode;
    mode = $urandom_range(99);
    if (mode < 55) begin
      lo = $urandom_range(4 * active_side);
      hi = lo + $urandom_range(3 * active_side);
    end else if (mode < 75) begin
      lo = $urandom_range(COORD_MAX);
      hi = $urandom_range(COORD_MAX);
      if (hi < lo) begin
        hi = lo + (hi & 1023);
      end
    end else if (mode < 90) begin
      hi = COORD_MAX - $urandom_range(3 * active_side);
      lo = hi - $urandom_range(hi);
    end else begin
      hi = $urandom_range(4 * active_side);
      lo = hi + 1 + $urandom_range(2 * active_side);
    end
    if (hi > COORD_MAX) hi = COORD_MAX;
  endtask

  // Reload n seeds with random content, the last load starting a build.
  task automatic load_tile(input int n);
    for (int i = 0; i < n; i++) send_load(i, $urandom, i == n - 1);
  endtask

  // Wait until every expected sum has come back, then wait out the SETTLE period.
  task automatic settle();
    in_valid <= 1'b0;
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half(input int hp);
    cfg_valid <= 1'b1;
    cfg_data  <= ptrs_pkg::HP_BITS'(hp);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  int half_list [8] = '{16, 0, 31, 5, 1, 3, 8, 2};
  int n_used, rl, rh, cl, ch, pick;

  initial begin
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    cmd            <= ptrs_pkg::OP_LOAD;
    seed_index     <= '0;
    seed_value     <= '0;
    seed_last      <= 1'b0;
    row_low        <= '0;
    col_low        <= '0;
    row_high       <= '0;
    col_high       <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    active_side    = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A query before any build must return zero.
    send_query(0, 0, 3, 3);
    // Load every seed position once so no later build reads an unwritten
    // seed; the extremes of the value go into the first two.
    send_load(0, '0, 1'b0);
    send_load(1, '1, 1'b0);
    for (int i = 2; i < ptrs_pkg::MAX_SEEDS; i++)
      send_load(i, $urandom, i == ptrs_pkg::MAX_SEEDS - 1);
    send_query(0, 0, 0, 0);
    send_query(0, 0, 1, 1);
    send_query(0, 0, COORD_MAX, COORD_MAX);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(5, 2, 1, 7);
    send_query(3, 3, 2, 2);
    send_query(0, 7, 9, 7);
    settle();

    // Random phases, each with its own half period and one of four idling patterns.
    for (int p = 0; p < 8; p++) begin
      write_half(half_list[p]);
      n_used = (half_list[p] == 0) ? 1 :
               ((half_list[p] > ptrs_pkg::MAX_SEEDS) ? ptrs_pkg::MAX_SEEDS : half_list[p]);
      active_side = 2 * n_used;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      load_tile(n_used);
      for (int k = 0; k < 80; k++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          load_tile(n_used);
        end else if (pick < 12) begin
          send_load($urandom_range(ptrs_pkg::MAX_SEEDS - 1), $urandom, $urandom_range(3) == 0);
        end else begin
          pick_span(rl, rh);
          pick_span(cl, ch);
          send_query(rl, cl, rh, ch);
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
